// ===== rtl/core/dsac_pkg.sv =====
// Shared constants and types for the depth sensor averaging and calibration block
package dsac_pkg;

	localparam int WINDOW_LEN_DEF = 16;
	localparam int SAMPLE_W       = 10;
	localparam int SAMPLE_MAX     = 1023;
	localparam int REG_W          = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int FRAC_SHIFT     = 8;
	// mean of 10-bit samples in Q.8 never exceeds 1023*256
	localparam int MEAN_W         = SAMPLE_W + FRAC_SHIFT;

	localparam logic signed [REG_W-1:0] SLOPE_RST      = 32'sd0;
	localparam logic signed [REG_W-1:0] OFFSET_RST     = 32'sd0;
	localparam logic signed [REG_W-1:0] FAULT_LOW_RST  = -32'sd32768;
	localparam logic signed [REG_W-1:0] FAULT_HIGH_RST = 32'sd1638400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE      = 2'd0,
		REG_OFFSET     = 2'd1,
		REG_FAULT_LOW  = 2'd2,
		REG_FAULT_HIGH = 2'd3
	} cfg_reg_t;

endpackage

// ===== rtl/core/dsac_sample_if.sv =====
// Sample channel: valid/ready transfer of one converter reading
interface dsac_sample_if;
	logic                          valid;
	logic                          ready;
	logic [dsac_pkg::SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== rtl/core/dsac_depth_if.sv =====
// Depth channel: valid/ready transfer of one calibrated depth and fault flag
interface dsac_depth_if;
	logic                              valid;
	logic                              ready;
	logic signed [dsac_pkg::REG_W-1:0] depth;
	logic                              sensor_fault;

	modport source (output valid, output depth, output sensor_fault, input ready);
	modport sink (input valid, input depth, input sensor_fault, output ready);
endinterface

// ===== rtl/core/depth_sensor_average_calibrate.sv =====
// Moving-average depth filter with linear calibration and fault window
// A sample passes through S_SUM, the serial divider S_DIV, then S_MUL, S_ADD and
// S_CMP to depth valid; the divider has DIV_W = 10 + clog2(WINDOW_LEN) + 8 bits.
// Samples are taken only in S_IDLE, after the last depth is registered; S_DIV is
// a restoring divider, one quotient bit per cycle; a waiting result stalls S_CMP.
// Reset: async; clears sequencer, pointer, fill, sum, datapath; cfg to defaults.
module depth_sensor_average_calibrate #(
	parameter int WINDOW_LEN = dsac_pkg::WINDOW_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dsac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dsac_pkg::REG_W-1:0]          cfg_data,
	dsac_sample_if.sink                         samples,
	dsac_depth_if.source                        depths
);

	localparam int PTR_W  = $clog2(WINDOW_LEN);
	localparam int SUM_W  = dsac_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int DIV_W  = SUM_W + dsac_pkg::FRAC_SHIFT;
	localparam int ITER_W = $clog2(DIV_W);
	localparam int PROD_W = dsac_pkg::REG_W + dsac_pkg::MEAN_W + 1;
	localparam int Z_W    = PROD_W - dsac_pkg::FRAC_SHIFT + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_MUL,
		S_ADD,
		S_CMP
	} state_t;

	state_t                                 state_q;
	logic signed [dsac_pkg::REG_W-1:0]      slope_q, offset_q, flo_q, fhi_q;
	logic [dsac_pkg::SAMPLE_W-1:0]          sample_q;
	logic [PTR_W-1:0]                       wp_q;
	logic                                   full_q;
	logic [SUM_W-1:0]                       sum_q;
	logic [CNT_W-1:0]                       cnt_q;
	logic [CNT_W-1:0]                       rem_q;
	logic [DIV_W-1:0]                       quo_q;
	logic [ITER_W-1:0]                      iter_q;
	logic signed [PROD_W-1:0]               prod_q;
	logic signed [Z_W-1:0]                  z_q;
	logic                                   out_valid_q;
	logic signed [dsac_pkg::REG_W-1:0]      depth_q;
	logic                                   fault_q;

	logic [dsac_pkg::SAMPLE_W-1:0]          ram_rdata;
	logic [dsac_pkg::SAMPLE_W-1:0]          old_sample;
	logic [PTR_W-1:0]                       wp_next;
	logic [SUM_W-1:0]                       sum_new;
	logic [CNT_W-1:0]                       cnt_new;
	logic [CNT_W:0]                         trial;
	logic                                   trial_ok;
	logic                                   in_xfer;
	logic                                   out_free;
	logic                                   z_fault;

	dsac_ram #(
		.WIDTH (dsac_pkg::SAMPLE_W),
		.DEPTH (WINDOW_LEN)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_SUM),
		.addr  (wp_q),
		.wdata (sample_q),
		.rdata (ram_rdata)
	);

	// entries past the fill point read as their cleared value
	assign old_sample = full_q ? ram_rdata : '0;
	assign wp_next    = (wp_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
	assign sum_new    = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
	assign cnt_new    = (full_q || wp_next == '0) ? CNT_W'(WINDOW_LEN) : CNT_W'(wp_next);

	assign trial      = {rem_q, quo_q[DIV_W-1]};
	assign trial_ok   = trial >= {1'b0, cnt_q};

	assign in_xfer    = samples.valid && samples.ready;
	assign out_free   = !out_valid_q || depths.ready;
	assign z_fault    = (z_q < Z_W'(flo_q)) || (z_q > Z_W'(fhi_q));

	assign samples.ready      = (state_q == S_IDLE);
	assign depths.valid       = out_valid_q;
	assign depths.depth       = depth_q;
	assign depths.sensor_fault = fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q  <= dsac_pkg::SLOPE_RST;
			offset_q <= dsac_pkg::OFFSET_RST;
			flo_q    <= dsac_pkg::FAULT_LOW_RST;
			fhi_q    <= dsac_pkg::FAULT_HIGH_RST;
		end else if (cfg_we) begin
			case (dsac_pkg::cfg_reg_t'(cfg_index))
				dsac_pkg::REG_SLOPE:      slope_q  <= cfg_data;
				dsac_pkg::REG_OFFSET:     offset_q <= cfg_data;
				dsac_pkg::REG_FAULT_LOW:  flo_q    <= cfg_data;
				dsac_pkg::REG_FAULT_HIGH: fhi_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sample_q    <= '0;
			wp_q        <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			iter_q      <= '0;
			prod_q      <= '0;
			z_q         <= '0;
			out_valid_q <= 1'b0;
			depth_q     <= '0;
			fault_q     <= 1'b0;
		end else begin
			if (out_valid_q && depths.ready && state_q != S_CMP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						sample_q <= samples.adc_sample;
						state_q  <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q   <= sum_new;
					wp_q    <= wp_next;
					full_q  <= full_q || (wp_next == '0);
					cnt_q   <= cnt_new;
					rem_q   <= '0;
					quo_q   <= {sum_new, {dsac_pkg::FRAC_SHIFT{1'b0}}};
					iter_q  <= ITER_W'(DIV_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= trial_ok ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
					quo_q  <= {quo_q[DIV_W-2:0], trial_ok};
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(slope_q) *
						PROD_W'($signed({1'b0, quo_q[dsac_pkg::MEAN_W-1:0]}));
					state_q <= S_ADD;
				end
				S_ADD: begin
					z_q     <= Z_W'(prod_q >>> dsac_pkg::FRAC_SHIFT) + Z_W'(offset_q);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						fault_q     <= z_fault;
						depth_q     <= z_fault ? '0 : z_q[dsac_pkg::REG_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sum_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |-> $past(in_xfer))
		else $error("sum update without a sample transfer");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(WINDOW_LEN * dsac_pkg::SAMPLE_MAX))
		else $error("window sum beyond its range");

	a_rem_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (rem_q < cnt_q))
		else $error("divider remainder not below count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (cnt_q != '0))
		else $error("divide by zero count");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !full_q) |-> (cnt_q == CNT_W'(wp_q)))
		else $error("warm-up count differs from write pointer");
`endif

endmodule

// ===== rtl/core/dsac_ram.sv =====
// Generic single-port RAM with registered read
module dsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[addr];
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

endmodule
